FILE: rtl/vspr_pkg.sv
// Shared types, constants and color tables for the palette scan-out block.
// It depends on nothing. Only the top level imports it.
package vspr_pkg;

  localparam int VRAM_WORDS         = 8192;
  localparam int VRAM_AW            = $clog2(VRAM_WORDS);
  localparam int SMALL_SCREEN_LINES = 64;
  localparam int SPAN_PIXELS        = 16;
  localparam int CNT_W              = $clog2(SPAN_PIXELS);
  localparam int CFG_IDX_W          = 3;

  localparam logic [7:0]  SCROLL_WRAP  = 8'o330;
  localparam logic [7:0]  SCROLL_BIAS  = 8'o50;
  localparam int          FULL_SCREEN_BIT = 9;   // octal 01000
  localparam logic [23:0] WHITE_RGB    = 24'hFFFFFF;
  localparam logic [7:0]  SMALL_LINES  = 8'(SMALL_SCREEN_LINES);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_PORT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATER_MODEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SELECT = 3'd3;

  // Input item actions
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT
  } vspr_state_t;

  typedef struct packed {
    logic        action;
    logic [12:0] word_address;
    logic [15:0] write_data;
    logic [7:0]  display_line;
    logic [4:0]  word_column;
  } vspr_in_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic [8:0]  pixel_column;
    logic [7:0]  image_row;
    logic        last_pixel;
  } vspr_out_t;

  localparam logic [23:0] FIXED_PALETTE [4] = '{
    24'h000000, 24'h0000FF, 24'h00FF00, 24'hFF0000
  };

  localparam logic [23:0] PALETTE_TABLE [16][4] = '{
    '{24'h000000, 24'h0000FF, 24'h00FF00, 24'hFF0000},
    '{24'h000000, 24'hFFFF00, 24'hFF00FF, 24'hFF0000},
    '{24'h000000, 24'h00FFFF, 24'h0000FF, 24'hFF00FF},
    '{24'h000000, 24'h00FF00, 24'h00FFFF, 24'hFFFF00},
    '{24'h000000, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF},
    '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
    '{24'h000000, 24'h7F0000, 24'h7F0000, 24'hFF0000},
    '{24'h000000, 24'h00FF7F, 24'h00FF7F, 24'hFFFF00},
    '{24'h000000, 24'hFF00FF, 24'h7F00FF, 24'h7F007F},
    '{24'h000000, 24'h00FF7F, 24'h7F00FF, 24'h7F0000},
    '{24'h000000, 24'h00FF7F, 24'h7F007F, 24'h7F0000},
    '{24'h000000, 24'h00FFFF, 24'hFFFF00, 24'hFF0000},
    '{24'h000000, 24'hFF0000, 24'h00FF00, 24'h00FFFF},
    '{24'h000000, 24'h00FFFF, 24'hFFFF00, 24'hFFFFFF},
    '{24'h000000, 24'hFFFF00, 24'h00FF00, 24'hFFFFFF},
    '{24'h000000, 24'h00FFFF, 24'h00FF00, 24'hFFFFFF}
  };

  // Scroll offset from the low byte of the scroll register, modulo 256
  function automatic logic [7:0] scroll_offset(input logic [7:0] s);
    logic [7:0] off;
    off = (s >= SCROLL_WRAP) ? 8'(s - SCROLL_WRAP) : 8'(s + SCROLL_BIAS);
    return off;
  endfunction

  function automatic logic [23:0] pair_color(input logic       later,
                                             input logic [3:0] pal,
                                             input logic [1:0] pair);
    logic [23:0] rgb;
    rgb = later ? PALETTE_TABLE[pal][pair] : FIXED_PALETTE[pair];
    return rgb;
  endfunction

endpackage

FILE: rtl/vspr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; contents are undefined until written.
module vspr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/video_scanout_palette_render.sv
// Top level of the palette scan-out block: config registers, sequencer,
// pixel shifter and output register. Depends on vspr_pkg and vspr_ram.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+---------------------------
//   in_     | input     | in_valid / in_ready   | vspr_in_t (write or render)
//   out_    | output    | out_valid / out_ready | vspr_out_t (one pixel)
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index + cfg_data
//
// A write word is written into the video RAM at the accept edge.
// A render word goes through ST_READ for the RAM read latency, then ST_SHIFT
// for 16 pixels, one per cycle unless out_ready stalls, set by the single read
// port and the one-pixel output register, then back to ST_IDLE, where the next
// word is taken. The first pixel shows after ST_READ, word_r and out_data_r.
// out_ready low stalls the shifter; the output register holds its word.
// Reset (rst_n, synchronous) clears the config registers and the sequencer;
// the video RAM gets no clearing pass and stays undefined until written.
module video_scanout_palette_render
  import vspr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vspr_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vspr_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers
  logic [15:0] scroll_port_r;
  logic        color_mode_r;
  logic        later_model_r;
  logic [3:0]  palette_select_r;

  // Sequencer and span context
  vspr_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      word_r;
  logic [7:0]       line_r;
  logic [4:0]       col_r;
  logic             blank_r;

  // Output register
  logic      out_valid_r;
  vspr_out_t out_data_r;

  // Control
  logic             in_fire;
  logic             cfg_fire;
  logic             emit;
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       src_row;
  logic [VRAM_AW-1:0] ram_raddr;
  logic [15:0]      ram_rdata;
  logic [1:0]       pair;
  logic [23:0]      pix_rgb;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Decode config writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_port_r    <= '0;
      color_mode_r     <= 1'b0;
      later_model_r    <= 1'b0;
      palette_select_r <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_SCROLL_PORT:    scroll_port_r    <= cfg_data;
        CFG_COLOR_MODE:     color_mode_r     <= cfg_data[0];
        CFG_LATER_MODEL:    later_model_r    <= cfg_data[0];
        CFG_PALETTE_SELECT: palette_select_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Source row after scroll; the RAM is laid out as row * 32 + column
  assign src_row   = 8'(in_data.display_line + scroll_offset(scroll_port_r[7:0]));
  assign ram_raddr = {src_row, in_data.word_column};

  assign in_fire = in_valid && in_ready;
  assign ram_we  = in_fire && (in_data.action == ACT_WRITE);
  assign ram_re  = in_fire && (in_data.action == ACT_RENDER);

  vspr_ram #(
    .WIDTH (16),
    .DEPTH (VRAM_WORDS)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.word_address),
    .wdata (in_data.write_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state: take words only when idle, advance one pixel per free slot
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_data.action == ACT_RENDER) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        emit = !out_valid_r || out_ready;
        if (emit && cnt_r == CNT_W'(SPAN_PIXELS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_READ) begin
        cnt_r <= '0;
      end else if (emit) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Capture span context at accept, the video word after the read latency
  always_ff @(posedge clk) begin
    if (ram_re) begin
      line_r  <= in_data.display_line;
      col_r   <= in_data.word_column;
      blank_r <= !scroll_port_r[FULL_SCREEN_BIT] && (in_data.display_line >= SMALL_LINES);
    end
    if (state_r == ST_READ) begin
      word_r <= ram_rdata;
    end
  end

  // Pixel color: bit per pixel in monochrome, bit pair per double pixel in color
  assign pair = word_r[{cnt_r[CNT_W-1:1], 1'b0} +: 2];

  always_comb begin
    if (blank_r) begin
      pix_rgb = '0;
    end else if (color_mode_r) begin
      pix_rgb = pair_color(later_model_r, palette_select_r, pair);
    end else begin
      pix_rgb = word_r[cnt_r] ? WHITE_RGB : 24'h000000;
    end
  end

  // Output register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.pixel_rgb    <= pix_rgb;
      out_data_r.pixel_column <= {col_r, cnt_r};
      out_data_r.image_row    <= 8'(8'd255 - line_r);
      out_data_r.last_pixel   <= (cnt_r == CNT_W'(SPAN_PIXELS - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_render_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.action == ACT_RENDER) |=> (state_r == ST_READ))
    else $error("render word did not start a RAM read");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.action == ACT_WRITE && !out_valid) |=> !out_valid)
    else $error("write word produced a pixel");

  a_last_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_pixel) |-> (out_data.pixel_column[CNT_W-1:0] == '1))
    else $error("last pixel flag off the span end");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !out_valid) |=> !out_valid)
    else $error("pixel emitted with no span in progress");
`endif

endmodule
